@@ design/tttt_pkg.sv @@
// ----------------------------------------------------------------------------
// tttt_pkg: thread trap tracking table shared definitions
// Result codes, trap change codes, entry record and sequencer states.
// ----------------------------------------------------------------------------
package tttt_pkg;

    localparam int unsigned TABLE_DEPTH_DEFAULT = 64;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_DISABLED  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FLAG_CLR  = 3'd4;

    localparam logic [1:0] TC_LEAVE = 2'd0;
    localparam logic [1:0] TC_SET   = 2'd1;
    localparam logic [1:0] TC_CLEAR = 2'd2;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] ctx;
        logic [63:0] wa;
        logic [63:0] wb;
        logic [63:0] wc;
        logic [63:0] wd;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_INS,
        S_DEL,
        S_OUT
    } state_t;

endpackage

@@ design/thread_trap_tracking_table.sv @@
// ----------------------------------------------------------------------------
// thread_trap_tracking_table: sorted key table with record and check
// Channel   | signals                      | accepted when
// in        | in_valid, in_ready, fields   | in_valid && in_ready
// out       | out_valid, out_ready, fields | out_valid && out_ready
// cfg       | cfg_we, cfg_wdata            | cfg_we
// One transaction at a time; in_ready is low from the accepting edge until the
// sequencer is back in idle and the previous result has been taken.
// Search: each entry looked at is read, then compared; past the last entry it
// decides on the count alone; the result is registered at the deciding edge.
// Insert then moves each later entry up one slot (read, write); delete moves
// one entry per cycle and then drops the count. Reset clears count, enable
// and control; the memory keeps no reset. A stalled out_ready holds off the
// next transaction.
// ----------------------------------------------------------------------------
module thread_trap_tracking_table #(
    parameter int unsigned TABLE_DEPTH = tttt_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] process_id,
    input  logic [31:0] thread_id,
    input  logic [63:0] caller_context,
    input  logic [63:0] extra_word_a,
    input  logic [63:0] extra_word_b,
    input  logic [63:0] extra_word_c,
    input  logic [63:0] extra_word_d,
    input  logic        trap_flag_now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [2:0]  status,
    output logic [1:0]  trap_change,
    output logic [63:0] found_context,
    output logic [63:0] found_word_a,
    output logic [63:0] found_word_b,
    output logic [63:0] found_word_c,
    output logic [63:0] found_word_d
);
    import tttt_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    state_t state_reg, state_next;
    logic          en_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rdv_reg, rdv_next;
    logic          cmd_reg;
    entry_t        item_reg;
    entry_t        carry_reg;
    logic          ovalid_reg, ovalid_next;
    logic          ok_reg, ok_next;
    logic [2:0]    st_reg, st_next;
    logic [1:0]    tc_reg, tc_next;
    entry_t        fnd_reg, fnd_next;
    logic          take;
    logic          done;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign take = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            en_reg     <= 1'b0;
            count_reg  <= '0;
            idx_reg    <= '0;
            rdv_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            rdv_reg    <= rdv_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                en_reg <= cfg_wdata;
                // enabling from off empties the table
                if (cfg_wdata && !en_reg)
                begin
                    count_reg <= '0;
                end
                else
                begin
                    count_reg <= count_next;
                end
            end
            else
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg       <= cmd;
            item_reg.key  <= {thread_id, process_id};
            item_reg.ctx  <= caller_context;
            item_reg.wa   <= extra_word_a;
            item_reg.wb   <= extra_word_b;
            item_reg.wc   <= extra_word_c;
            item_reg.wd   <= extra_word_d;
        end
        if (done)
        begin
            ok_reg  <= ok_next;
            st_reg  <= st_next;
            tc_reg  <= tc_next;
            fnd_reg <= fnd_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rdv_next     = 1'b0;
        ovalid_next  = ovalid_reg;
        done         = 1'b0;
        ok_next      = 1'b0;
        st_next      = ST_DONE;
        tc_next      = TC_LEAVE;
        fnd_next     = '0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = idx_reg[AW-1:0];
        wr_data      = item_reg;

        if (out_valid && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (cmd == CMD_CHECK && !trap_flag_now)
                    begin
                        done = 1'b1;
                        st_next = ST_FLAG_CLR;
                        ovalid_next = 1'b1;
                    end
                    else if (!en_reg)
                    begin
                        done = 1'b1;
                        st_next = (cmd == CMD_RECORD) ? ST_DISABLED : ST_NOT_FOUND;
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = '0;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                // rdv_reg marks rd_data as the entry at idx_reg
                if (rdv_reg && rd_data.key == item_reg.key)
                begin
                    if (cmd_reg == CMD_RECORD)
                    begin
                        done = 1'b1;
                        ok_next = 1'b1;
                        tc_next = TC_SET;
                        ovalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        done = 1'b1;
                        ok_next = 1'b1;
                        tc_next = TC_CLEAR;
                        fnd_next = rd_data;
                        ovalid_next = 1'b1;
                        state_next = S_DEL;
                        rd_addr = AW'(idx_reg + 1'b1);
                        rd_en = (idx_reg + 1'b1 < count_reg);
                        rdv_next = rd_en;
                    end
                end
                else if ((rdv_reg && rd_data.key > item_reg.key)
                         || (!rdv_reg && idx_reg >= count_reg))
                begin
                    // insertion point or end of search
                    if (cmd_reg == CMD_CHECK)
                    begin
                        done = 1'b1;
                        st_next = ST_NOT_FOUND;
                        ovalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (count_reg >= DEPTH_C)
                    begin
                        done = 1'b1;
                        st_next = ST_FULL;
                        ovalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // write new item here, carry the old entry upward
                        done = 1'b1;
                        ok_next = 1'b1;
                        tc_next = TC_SET;
                        ovalid_next = 1'b1;
                        wr_en = 1'b1;
                        wr_data = item_reg;
                        count_next = count_reg + 1'b1;
                        if (idx_reg < count_reg)
                        begin
                            idx_next = idx_reg + 1'b1;
                            state_next = S_INS;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (rdv_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    rd_en = 1'b1;
                    rdv_next = 1'b1;
                end
            end
            S_INS:
            begin
                // carry_reg holds the entry displaced from idx-1; read idx, write carry
                if (!rdv_reg && idx_reg < count_reg - 1'b1)
                begin
                    rd_en = 1'b1;
                    rdv_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_data = carry_reg;
                    if (idx_reg >= count_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_DEL:
            begin
                if (rdv_reg)
                begin
                    wr_en = 1'b1;
                    wr_data = rd_data;
                    idx_next = idx_reg + 1'b1;
                    rd_addr = AW'(idx_reg + 2'd2);
                    rd_en = ({1'b0, idx_reg} + 2'd2 < {1'b0, count_reg});
                    rdv_next = rd_en;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // capture each entry as it is read so the write one slot up can take it
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SEARCH && state_next == S_INS)
        begin
            carry_reg <= rd_data;
        end
        else if (state_reg == S_INS && rdv_reg)
        begin
            carry_reg <= rd_data;
        end
    end

    assign out_valid     = ovalid_reg;
    assign ok            = ok_reg;
    assign status        = st_reg;
    assign trap_change   = tc_reg;
    assign found_context = fnd_reg.ctx;
    assign found_word_a  = fnd_reg.wa;
    assign found_word_b  = fnd_reg.wb;
    assign found_word_c  = fnd_reg.wc;
    assign found_word_d  = fnd_reg.wd;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C) else $error("entry count above depth");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready) else $error("ready while busy");
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> status == ST_DONE) else $error("ok with error status");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: thread trap tracking table testbench
// Drives record and check commands, predicts each result from a sorted
// key table kept here, and checks every output field against it.
// ----------------------------------------------------------------------------
module tb_top;
    import tttt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = TABLE_DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        ok;
        logic [2:0]  status;
        logic [1:0]  trap_change;
        logic [63:0] ctx;
        logic [63:0] wa;
        logic [63:0] wb;
        logic [63:0] wc;
        logic [63:0] wd;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic [31:0] process_id = '0;
    logic [31:0] thread_id = '0;
    logic [63:0] caller_context = '0;
    logic [63:0] extra_word_a = '0;
    logic [63:0] extra_word_b = '0;
    logic [63:0] extra_word_c = '0;
    logic [63:0] extra_word_d = '0;
    logic        trap_flag_now = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        ok;
    logic [2:0]  status;
    logic [1:0]  trap_change;
    logic [63:0] found_context;
    logic [63:0] found_word_a;
    logic [63:0] found_word_b;
    logic [63:0] found_word_c;
    logic [63:0] found_word_d;

    thread_trap_tracking_table uut (.*);

    always #10 clk = ~clk;

    // Shadow of the table
    entry_t   shadow [DEPTH];
    int       shadow_count = 0;
    logic     shadow_enable = 1'b0;
    verdict_t pending_verdicts[$];
    logic [63:0] recorded_keys[$];
    int       errors = 0;
    int       idle_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    function automatic verdict_t apply_command(logic c, logic [63:0] key, logic [63:0] ctx,
                                               logic [63:0] wa, logic [63:0] wb,
                                               logic [63:0] wc, logic [63:0] wd, logic tf);
        verdict_t v;
        int pos;
        bit hit;
        v = '0;
        pos = 0;
        hit = 0;
        if (shadow_enable)
        begin
            while (pos < shadow_count)
            begin
                if (shadow[pos].key == key)
                begin
                    hit = 1;
                    break;
                end
                if (shadow[pos].key > key)
                    break;
                pos++;
            end
        end
        if (c == CMD_RECORD)
        begin
            if (!shadow_enable)
                v.status = ST_DISABLED;
            else if (!hit && shadow_count >= DEPTH)
                v.status = ST_FULL;
            else
            begin
                if (!hit)
                begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow[i] = shadow[i-1];
                    shadow[pos] = '{key, ctx, wa, wb, wc, wd};
                    shadow_count++;
                end
                v.ok = 1'b1;
                v.status = ST_DONE;
                v.trap_change = TC_SET;
            end
        end
        else if (!tf)
            v.status = ST_FLAG_CLR;
        else if (!hit)
            v.status = ST_NOT_FOUND;
        else
        begin
            v.ok = 1'b1;
            v.status = ST_DONE;
            v.trap_change = TC_CLEAR;
            v.ctx = shadow[pos].ctx;
            v.wa = shadow[pos].wa;
            v.wb = shadow[pos].wb;
            v.wc = shadow[pos].wc;
            v.wd = shadow[pos].wd;
            for (int i = pos; i + 1 < shadow_count; i++)
                shadow[i] = shadow[i+1];
            shadow_count--;
        end
        return v;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_command(logic c, logic [63:0] key, logic [63:0] ctx, logic [63:0] wa,
                                logic [63:0] wb, logic [63:0] wc, logic [63:0] wd, logic tf);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid <= 1'b1;
        cmd <= c;
        process_id <= key[31:0];
        thread_id <= key[63:32];
        caller_context <= ctx;
        extra_word_a <= wa;
        extra_word_b <= wb;
        extra_word_c <= wc;
        extra_word_d <= wd;
        trap_flag_now <= tf;
        pending_verdicts.push_back(apply_command(c, key, ctx, wa, wb, wc, wd, tf));
        if (c == CMD_RECORD && shadow_enable)
            recorded_keys.push_back(key);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_valid <= 1'b0;
        // the block is busy after a transaction, so step past this edge
        @(posedge clk);
    endtask

    task automatic send_random(logic c, logic [63:0] key, logic tf);
        send_command(c, key, rand64(), rand64(), rand64(), rand64(), rand64(), tf);
    endtask

    // Hold until every result is back, then let an in-flight insert or delete finish
    task automatic drain_and_set_enable(logic en);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= en;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (en && !shadow_enable)
        begin
            shadow_count = 0;
            recorded_keys.delete();
        end
        shadow_enable = en;
    endtask

    function automatic int u_small();
        return $urandom_range(7);
    endfunction

    function automatic logic [63:0] pick_key();
        if (recorded_keys.size() != 0 && $urandom_range(3) != 0)
            return recorded_keys[$urandom_range(recorded_keys.size() - 1)];
        case ($urandom_range(3))
            0: return 64'd0;
            1: return '1;
            2: return {32'(u_small()), 32'(u_small())};
            default: return rand64();
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                verdict_t e;
                e = pending_verdicts.pop_front();
                if (ok !== e.ok)
                begin
                    $error("ok exp %0h got %0h", e.ok, ok);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $error("status exp %0h got %0h", e.status, status);
                    errors++;
                end
                if (trap_change !== e.trap_change)
                begin
                    $error("trap_change exp %0h got %0h", e.trap_change, trap_change);
                    errors++;
                end
                if (found_context !== e.ctx)
                begin
                    $error("found_context exp %0h got %0h", e.ctx, found_context);
                    errors++;
                end
                if (found_word_a !== e.wa)
                begin
                    $error("found_word_a exp %0h got %0h", e.wa, found_word_a);
                    errors++;
                end
                if (found_word_b !== e.wb)
                begin
                    $error("found_word_b exp %0h got %0h", e.wb, found_word_b);
                    errors++;
                end
                if (found_word_c !== e.wc)
                begin
                    $error("found_word_c exp %0h got %0h", e.wc, found_word_c);
                    errors++;
                end
                if (found_word_d !== e.wd)
                begin
                    $error("found_word_d exp %0h got %0h", e.wd, found_word_d);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || pending_verdicts.size() == 0)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_disabled();
        send_random(CMD_RECORD, 64'h1, 1'b1);
        send_random(CMD_CHECK, 64'h1, 1'b1);
        send_random(CMD_CHECK, 64'h1, 1'b0);
    endtask

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        drain_and_set_enable(1'b1);
        send_command(CMD_RECORD, 64'd0, '0, '0, '0, '0, '0, 1'b0);
        send_command(CMD_RECORD, ones, ones, ones, ones, ones, ones, 1'b1);
        send_random(CMD_RECORD, 64'h5, 1'b0);
        send_random(CMD_RECORD, 64'h5, 1'b0);  // present key keeps payload
        send_random(CMD_CHECK, 64'h5, 1'b0);   // flag clear
        send_random(CMD_CHECK, 64'h6, 1'b1);   // miss
        send_random(CMD_CHECK, 64'h5, 1'b1);
        send_random(CMD_CHECK, ones, 1'b1);
        send_random(CMD_CHECK, 64'd0, 1'b1);
        drain_and_set_enable(1'b1);            // already on: no effect
        send_random(CMD_RECORD, 64'h9, 1'b0);
        drain_and_set_enable(1'b0);
        drain_and_set_enable(1'b1);            // off to on: empties table
        send_random(CMD_CHECK, 64'h9, 1'b1);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < DEPTH; i++)
            send_random(CMD_RECORD, rand64(), 1'b0);
        send_random(CMD_RECORD, 64'hDEAD, 1'b0);
        send_random(CMD_RECORD, recorded_keys[3], 1'b0);
        send_random(CMD_CHECK, recorded_keys[7], 1'b1);
        send_random(CMD_RECORD, 64'hDEAD, 1'b0);
    endtask

    task automatic test_random(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            logic c;
            c = ($urandom_range(1) == 1) ? CMD_CHECK : CMD_RECORD;
            send_random(c, pick_key(), $urandom_range(9) != 0);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disabled();
        test_directed();
        test_full_table();
        drain_and_set_enable(1'b0);
        drain_and_set_enable(1'b1);
        test_random(150, 0, 0);
        test_random(150, 80, 0);
        test_random(150, 0, 80);
        drain_and_set_enable(1'b0);
        test_random(20, 8, 8);
        drain_and_set_enable(1'b1);
        test_random(130, 8, 8);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
